>>> rtl/cle_pkg.sv
// Shared types and constants for the canonical line editor.
// Used by cle_ctrl, cle_datapath and canonical_line_editor.
package cle_pkg;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;

	typedef enum logic [1:0] {
		OSEL_INPUT,
		OSEL_LINE,
		OSEL_NEWLINE
	} out_sel_t;

	typedef struct packed {
		logic     store;
		logic     fill_dec;
		logic     drain_start;
		logic     rd_adv;
		logic     out_load;
		out_sel_t out_sel;
		logic     out_last;
	} cle_cmd_t;

	typedef struct packed {
		logic is_nl;
		logic is_bs;
		logic fill_zero;
		logic fill_full;
		logic rd_last;
		logic out_free;
	} cle_status_t;

endpackage

>>> rtl/cle_ctrl.sv
// Controller state machine of the canonical line editor.
// Depends on cle_pkg; drives cle_datapath through cle_cmd_t.
module cle_ctrl import cle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        echo_on,
	input  cle_status_t st,
	output cle_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_DRAIN_RD = 2'd1;
	localparam logic [1:0] ST_DRAIN_WR = 2'd2;
	localparam logic [1:0] ST_ECHO_NL  = 2'd3;

	logic [1:0] state_q, state_d;
	logic       echo_q;
	logic       in_fire;

	assign s_tready = (state_q == ST_IDLE) && st.out_free;
	assign in_fire  = s_tvalid && s_tready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (st.is_nl) begin
						if (!st.fill_zero) begin
							cmd.drain_start = 1'b1;
							state_d = ST_DRAIN_RD;
						end else if (echo_on) begin
							cmd.out_load = 1'b1;
							cmd.out_sel  = OSEL_NEWLINE;
							cmd.out_last = 1'b1;
						end
					end else if (st.is_bs) begin
						if (!st.fill_zero) begin
							cmd.fill_dec = 1'b1;
							cmd.out_load = echo_on;
							cmd.out_sel  = OSEL_INPUT;
							cmd.out_last = 1'b1;
						end
					end else if (!st.fill_full) begin
						cmd.store    = 1'b1;
						cmd.out_load = echo_on;
						cmd.out_sel  = OSEL_INPUT;
						cmd.out_last = 1'b1;
					end
				end
			end
			ST_DRAIN_RD: begin
				state_d = ST_DRAIN_WR;
			end
			ST_DRAIN_WR: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_LINE;
					cmd.out_last = st.rd_last && !echo_q;
					cmd.rd_adv   = 1'b1;
					if (st.rd_last) begin
						state_d = echo_q ? ST_ECHO_NL : ST_IDLE;
					end else begin
						state_d = ST_DRAIN_RD;
					end
				end
			end
			ST_ECHO_NL: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_NEWLINE;
					cmd.out_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			echo_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.drain_start) begin
				echo_q <= echo_on;
			end
		end
	end

	a_drain_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input accepted during line drain");

	a_drain_follows_newline: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain_start |=> (state_q == ST_DRAIN_RD))
		else $error("drain did not start after newline");

endmodule

>>> rtl/cle_datapath.sv
// Datapath of the canonical line editor: line memory, fill count, read pointer
// and output register. Depends on cle_pkg; controlled by cle_ctrl.
module cle_datapath import cle_pkg::*; #(
	parameter int LINE_LENGTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  char_in,
	input  cle_cmd_t    cmd,
	output cle_status_t st,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        out_kind,
	output logic [7:0]  out_byte,
	output logic        out_last
);

	localparam int CAP    = LINE_LENGTH - 1;
	localparam int FILL_W = $clog2(LINE_LENGTH);
	localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;

	logic [7:0]        mem [CAP];
	logic [7:0]        rdata_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_m1;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic [IDX_W-1:0]  last_idx_q;
	logic              out_valid_q;
	logic              out_kind_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic [7:0]        out_byte_d;

	assign fill_m1 = fill_q - FILL_W'(1);

	assign st.is_nl     = (char_in == CH_NEWLINE);
	assign st.is_bs     = (char_in == CH_BACKSPACE);
	assign st.fill_zero = (fill_q == '0);
	assign st.fill_full = (fill_q == FILL_W'(CAP));
	assign st.rd_last   = (rd_ptr_q == last_idx_q);
	assign st.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[fill_q[IDX_W-1:0]] <= char_in;
		end
		rdata_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_ptr_q <= '0;
		end else begin
			priority if (cmd.store) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (cmd.fill_dec) begin
				fill_q <= fill_m1;
			end else if (cmd.drain_start) begin
				fill_q <= '0;
			end
			priority if (cmd.drain_start) begin
				rd_ptr_q <= '0;
			end else if (cmd.rd_adv) begin
				rd_ptr_q <= rd_ptr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain_start) begin
			last_idx_q <= fill_m1[IDX_W-1:0];
		end
	end

	always_comb begin
		unique case (cmd.out_sel)
			OSEL_INPUT:   out_byte_d = char_in;
			OSEL_LINE:    out_byte_d = rdata_q;
			OSEL_NEWLINE: out_byte_d = CH_NEWLINE;
			default:      out_byte_d = char_in;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_kind_q <= (cmd.out_sel == OSEL_LINE);
			out_byte_q <= out_byte_d;
			out_last_q <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CAP))
		else $error("fill count beyond line capacity");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("output register overwritten before transfer");

	a_store_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !st.fill_full)
		else $error("store into full line");

endmodule

>>> rtl/canonical_line_editor.sv
// Canonical-mode line editor: echo, backspace and line release on newline.
// Ordinary bytes and backspaces: the echo is registered and shows in the cycle after the transfer;
// input is taken only while the output register is free. Newline with stored bytes: each is read
// through the one memory read port, then loaded for output, then the newline echo when echo is on.
// Input is held off while draining. Reset (arst_n low, asynchronous) empties the line, sets echo on.
// Depends on cle_pkg, cle_ctrl and cle_datapath.
module canonical_line_editor import cle_pkg::*; #(
	parameter int LINE_LENGTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // burst_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // out_kind
	output logic       m_tlast    // out_last
);

	cle_cmd_t    cmd;
	cle_status_t st;
	logic        echo_on_q;
	logic        burst_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_on_q <= 1'b1;
		end else if (cfg_wr_en) begin
			echo_on_q <= cfg_wr_data;
		end
	end

	// burst framing carries no meaning for line editing
	assign burst_end = s_tlast;

	cle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.echo_on  (echo_on_q),
		.st       (st),
		.cmd      (cmd)
	);

	cle_datapath #(
		.LINE_LENGTH (LINE_LENGTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (s_tdata),
		.cmd       (cmd),
		.st        (st),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_kind  (m_tuser),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

	a_burst_end_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && !s_tready) |=> $stable(burst_end) || !s_tvalid || s_tready
			|| $past(s_tvalid && !s_tready))
		else $error("burst marker check failed");

endmodule

>>> tb/cle_line_checker.sv
`timescale 1ns / 100ps
// Scoreboard for canonical_line_editor: tracks config writes and input transfers,
// predicts the echo and completed-line output transfers and compares them in order.
// Depends on cle_pkg.
module cle_line_checker import cle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tuser,
	input  logic       m_tlast,
	output int         fail_count,
	output int         pending
);

	localparam int   LINE_CAP  = 63;
	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_LINE = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} edit_result_t;

	edit_result_t line_results[$];
	logic [7:0]   line_text [LINE_CAP];
	int           text_count;
	logic         echo_en;
	int           mismatches;

	task automatic post_result(input logic kind, input logic [7:0] data);
		edit_result_t r;
		r.kind = kind;
		r.data = data;
		r.last = 1'b0;
		line_results.push_back(r);
	endtask

	task automatic edit_line(input logic [7:0] ch);
		int base;
		edit_result_t r;
		base = line_results.size();
		if (ch == CH_NEWLINE) begin
			for (int i = 0; i < text_count; i++)
				post_result(KIND_LINE, line_text[i]);
			text_count = 0;
			if (echo_en)
				post_result(KIND_ECHO, CH_NEWLINE);
		end else if (ch == CH_BACKSPACE) begin
			if (text_count > 0) begin
				text_count--;
				if (echo_en)
					post_result(KIND_ECHO, CH_BACKSPACE);
			end
		end else if (text_count < LINE_CAP) begin
			line_text[text_count] = ch;
			text_count++;
			if (echo_en)
				post_result(KIND_ECHO, ch);
		end
		if (line_results.size() > base) begin
			r = line_results[line_results.size() - 1];
			r.last = 1'b1;
			line_results[line_results.size() - 1] = r;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		edit_result_t want;
		if (!arst_n) begin
			line_results.delete();
			text_count = 0;
			echo_en    = 1'b1;
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_wr_en)
				echo_en = cfg_wr_data;
			if (s_tvalid && s_tready)
				edit_line(s_tdata);
			if (m_tvalid && m_tready) begin
				if (line_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: kind %0d byte 0x%02h last %0d",
							m_tuser, m_tdata, m_tlast);
				end else begin
					want = line_results.pop_front();
					if (m_tuser !== want.kind || m_tdata !== want.data ||
							m_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("mismatch: expected kind %0d byte 0x%02h last %0d,",
								want.kind, want.data, want.last);
							$display(" got kind %0d byte 0x%02h last %0d",
								m_tuser, m_tdata, m_tlast);
						end
					end
				end
			end
			fail_count <= mismatches;
			pending    <= line_results.size();
		end
	end

endmodule

>>> tb/canonical_line_editor_test.sv
`timescale 1ns / 100ps
// Testbench top for canonical_line_editor: resets the block, writes the echo flag
// between phases, sends directed and random character streams and reports the verdict.
// Depends on cle_pkg, canonical_line_editor and cle_line_checker.
module canonical_line_editor_test;
	import cle_pkg::*;

	localparam int RANDOM_ITEMS = 210;
	localparam int STEADY_FROM  = 170;
	localparam int PHASE_ITEMS  = 70;
	localparam int QUIET_LIMIT  = 400;
	localparam int END_WAIT     = 20;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       s_tvalid    = 1'b0;
	logic [7:0] s_tdata     = 8'd0;
	logic       s_tlast     = 1'b0;
	logic       m_tready    = 1'b0;
	logic       steady      = 1'b0;
	logic       s_tready;
	logic       m_tvalid;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;
	int         fail_count;
	int         pending;
	int         items_sent  = 0;
	int         quiet_cycles = 0;
	int         stall_left  = 0;

	canonical_line_editor u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	cle_line_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_char(input logic [7:0] ch);
		int gap;
		if (!steady && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= 1'($urandom_range(0, 1));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_line(input int len, input int bs_pct);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < bs_pct)
				send_char(CH_BACKSPACE);
			else
				send_char(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 9) != 0)
			send_char(CH_NEWLINE);
	endtask

	// hold input off until every predicted transfer has arrived
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_echo(input logic value);
		drain();
		repeat (8) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		int  phase;
		int  phase_start;
		int  lines;
		logic long_line;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_char(CH_BACKSPACE);
		send_char(CH_NEWLINE);
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h7F);
		send_char(8'h80);
		send_char(8'h41);
		send_char(CH_BACKSPACE);
		send_char(CH_NEWLINE);
		write_echo(1'b0);
		send_char(8'h58);
		send_char(8'h59);
		send_char(CH_BACKSPACE);
		send_char(CH_NEWLINE);
		send_char(CH_NEWLINE);
		send_char(CH_BACKSPACE);
		write_echo(1'b1);

		phase = 0;
		lines = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (phase > 0)
				write_echo(phase == 1 ? 1'b0 : phase == 2 ? 1'b1 : 1'($urandom_range(0, 1)));
			phase_start = items_sent;
			while (items_sent < RANDOM_ITEMS && items_sent - phase_start < PHASE_ITEMS) begin
				if (items_sent >= STEADY_FROM)
					steady <= 1'b1;
				long_line = (lines == 0) || ($urandom_range(0, 9) == 0);
				if (long_line)
					send_line($urandom_range(60, 70), 4);
				else
					send_line($urandom_range(0, 10), 15);
				lines++;
			end
			phase++;
		end

		drain();
		repeat (END_WAIT) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
rtl/cle_pkg.sv
rtl/cle_ctrl.sv
rtl/cle_datapath.sv
rtl/canonical_line_editor.sv
tb/cle_line_checker.sv
tb/canonical_line_editor_test.sv
